[rtl/gcrb_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package gcrb_pkg;

  localparam int unsigned ANGLE_FRAC_BITS   = 16;
  localparam int unsigned CORDIC_STAGES_DEF = 20;

  localparam int unsigned LAT_W  = 24;
  localparam int unsigned LON_W  = 25;
  localparam int unsigned ANG_W  = 25;
  localparam int unsigned TURN_W = 32;
  localparam int unsigned SC_W   = 32;
  localparam int unsigned XV_W   = SC_W + 1;

  localparam int unsigned NUM_LANES = 3;
  localparam int unsigned LN_OWN    = 0;
  localparam int unsigned LN_GOAL   = 1;
  localparam int unsigned LN_DLON   = 2;

  localparam logic [ANG_W-1:0]  FULL_CIRCLE  = ANG_W'(360 << ANGLE_FRAC_BITS);
  localparam logic [TURN_W-1:0] TURN_HALF    = 32'h8000_0000;
  localparam logic [TURN_W-1:0] TURN_QUARTER = 32'h4000_0000;
  localparam int                GAIN_INV_Q30 = 652032874;
  // ceil(2^31 / 45), exact quotient for any 25-bit dividend
  localparam logic [25:0]       RECIP45      = 26'd47721859;
  localparam int unsigned       RECIP45_SH   = 31;

  function automatic int unsigned pipe_latency(input int unsigned stages);
    return 2 * stages + 11;
  endfunction

  function automatic logic [TURN_W-1:0] atan_turn(input logic [4:0] k);
    logic [TURN_W-1:0] r;
    unique case (k)
      5'd0:  r = 32'h2000_0000;
      5'd1:  r = 32'h12E4_051E;
      5'd2:  r = 32'h09FB_385B;
      5'd3:  r = 32'h0511_11D4;
      5'd4:  r = 32'h028B_0D43;
      5'd5:  r = 32'h0145_D7E1;
      5'd6:  r = 32'h00A2_F61E;
      5'd7:  r = 32'h0051_7C55;
      5'd8:  r = 32'h0028_BE53;
      5'd9:  r = 32'h0014_5F2F;
      5'd10: r = 32'h000A_2F98;
      5'd11: r = 32'h0005_17CC;
      5'd12: r = 32'h0002_8BE6;
      5'd13: r = 32'h0001_45F3;
      5'd14: r = 32'h0000_A2FA;
      5'd15: r = 32'h0000_517D;
      5'd16: r = 32'h0000_28BE;
      5'd17: r = 32'h0000_145F;
      5'd18: r = 32'h0000_0A30;
      5'd19: r = 32'h0000_0518;
      5'd20: r = 32'h0000_028C;
      5'd21: r = 32'h0000_0146;
      5'd22: r = 32'h0000_00A3;
      5'd23: r = 32'h0000_0051;
      5'd24: r = 32'h0000_0029;
      5'd25: r = 32'h0000_0014;
      5'd26: r = 32'h0000_000A;
      5'd27: r = 32'h0000_0005;
      5'd28: r = 32'h0000_0003;
      5'd29: r = 32'h0000_0001;
      5'd30: r = 32'h0000_0001;
      5'd31: r = 32'h0000_0000;
      default: r = 32'h0000_0000;
    endcase
    return r;
  endfunction

  // signed degree value (|v| < 2*FULL) into [0, FULL)
  function automatic logic [ANG_W-1:0] wrap_deg(input logic signed [26:0] v);
    logic signed [26:0] f;
    logic signed [26:0] r;
    f = $signed({2'b00, FULL_CIRCLE});
    priority if (v < -f) r = v + (f <<< 1);
    else if (v < 27'sd0)  r = v + f;
    else if (v >= f)      r = v - f;
    else                  r = v;
    return r[ANG_W-1:0];
  endfunction

endpackage

`default_nettype wire

[rtl/gcrb_front.sv]
`timescale 1ns / 1ps
`default_nettype none

// degrees -> binary turns, three lanes, three register stages
module gcrb_front import gcrb_pkg::*; (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               valid_i,
  input  logic [LAT_W-1:0]                   own_lat_i,
  input  logic [LON_W-1:0]                   own_lon_i,
  input  logic [LAT_W-1:0]                   goal_lat_i,
  input  logic [LON_W-1:0]                   goal_lon_i,
  output logic                               valid_o,
  output logic [NUM_LANES-1:0][TURN_W-1:0]   turn_o
);

  logic [2:0] vld_q;
  logic [NUM_LANES-1:0][ANG_W-1:0] u1_q, u2_q;
  logic [NUM_LANES-1:0][19:0]      a2_q;
  logic [NUM_LANES-1:0][TURN_W-1:0] t3_q;

  logic signed [26:0] dlon;
  assign dlon = $signed({{2{goal_lon_i[LON_W-1]}}, goal_lon_i})
              - $signed({{2{own_lon_i[LON_W-1]}}, own_lon_i});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    u1_q[LN_OWN]  <= wrap_deg(27'($signed(own_lat_i)));
    u1_q[LN_GOAL] <= wrap_deg(27'($signed(goal_lat_i)));
    u1_q[LN_DLON] <= wrap_deg(dlon);
  end

  // quotient by 45 via reciprocal
  always_ff @(posedge clk_i) begin
    for (int l = 0; l < NUM_LANES; l++) begin
      logic [50:0] p;
      p = 51'(u1_q[l]) * 51'(RECIP45);
      a2_q[l] <= p[50:RECIP45_SH];
      u2_q[l] <= u1_q[l];
    end
  end

  // turn = a*8192 + floor((r*8192+22)/45), r = u mod 45
  always_ff @(posedge clk_i) begin
    for (int l = 0; l < NUM_LANES; l++) begin
      logic [25:0] m45;
      logic [25:0] rem;
      logic [5:0]  r;
      logic [13:0] tab;
      m45 = 26'(a2_q[l]) * 26'd45;
      rem = 26'(u2_q[l]) - m45;
      r   = rem[5:0];
      tab = 14'(r) * 14'd182
          + ((r >= 6'd34) ? 14'd2 : ((r >= 6'd12) ? 14'd1 : 14'd0));
      t3_q[l] <= {a2_q[l][18:0], 13'b0} + 32'(tab);
    end
  end

  assign valid_o = vld_q[2];
  assign turn_o  = t3_q;

endmodule

`default_nettype wire

[rtl/gcrb_sincos.sv]
`timescale 1ns / 1ps
`default_nettype none

// rotation-mode CORDIC, one register per iteration, three lanes
module gcrb_sincos import gcrb_pkg::*; #(
  parameter int unsigned STAGES = CORDIC_STAGES_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             valid_i,
  input  logic [NUM_LANES-1:0][TURN_W-1:0] turn_i,
  output logic                             valid_o,
  output logic [NUM_LANES-1:0][SC_W-1:0]   sin_o,
  output logic [NUM_LANES-1:0][SC_W-1:0]   cos_o
);

  localparam int unsigned CR_W = 34;

  logic                  vld_q  [STAGES+2];
  logic signed [CR_W-1:0] x_q   [STAGES+1][NUM_LANES];
  logic signed [CR_W-1:0] y_q   [STAGES+1][NUM_LANES];
  logic signed [CR_W-1:0] z_q   [STAGES+1][NUM_LANES];
  logic                  flip_q [STAGES+1][NUM_LANES];
  logic [NUM_LANES-1:0][SC_W-1:0] sin_q, cos_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < STAGES + 2; s++) vld_q[s] <= 1'b0;
    end else begin
      vld_q[0] <= valid_i;
      for (int s = 1; s < STAGES + 2; s++) vld_q[s] <= vld_q[s-1];
    end
  end

  // fold into [-90,90), start vector on the x axis
  always_ff @(posedge clk_i) begin
    for (int l = 0; l < NUM_LANES; l++) begin
      logic [TURN_W-1:0] sum;
      logic [TURN_W-1:0] a;
      sum = turn_i[l] + TURN_QUARTER;
      a   = sum[TURN_W-1] ? (turn_i[l] - TURN_HALF) : turn_i[l];
      flip_q[0][l] <= sum[TURN_W-1];
      z_q[0][l]    <= $signed({{(CR_W-TURN_W){a[TURN_W-1]}}, a});
      x_q[0][l]    <= CR_W'(GAIN_INV_Q30);
      y_q[0][l]    <= '0;
    end
  end

  for (genvar gs = 0; gs < STAGES; gs++) begin : g_iter
    localparam logic [4:0] K = 5'(gs);
    always_ff @(posedge clk_i) begin
      for (int l = 0; l < NUM_LANES; l++) begin
        logic signed [CR_W-1:0] at;
        at = $signed({{(CR_W-TURN_W){1'b0}}, atan_turn(K)});
        if (!z_q[gs][l][CR_W-1]) begin
          x_q[gs+1][l] <= x_q[gs][l] - (y_q[gs][l] >>> gs);
          y_q[gs+1][l] <= y_q[gs][l] + (x_q[gs][l] >>> gs);
          z_q[gs+1][l] <= z_q[gs][l] - at;
        end else begin
          x_q[gs+1][l] <= x_q[gs][l] + (y_q[gs][l] >>> gs);
          y_q[gs+1][l] <= y_q[gs][l] - (x_q[gs][l] >>> gs);
          z_q[gs+1][l] <= z_q[gs][l] + at;
        end
        flip_q[gs+1][l] <= flip_q[gs][l];
      end
    end
  end

  // undo the half-turn fold
  always_ff @(posedge clk_i) begin
    for (int l = 0; l < NUM_LANES; l++) begin
      logic signed [CR_W-1:0] xf, yf;
      xf = flip_q[STAGES][l] ? -x_q[STAGES][l] : x_q[STAGES][l];
      yf = flip_q[STAGES][l] ? -y_q[STAGES][l] : y_q[STAGES][l];
      cos_q[l] <= xf[SC_W-1:0];
      sin_q[l] <= yf[SC_W-1:0];
    end
  end

  assign valid_o = vld_q[STAGES+1];
  assign sin_o   = sin_q;
  assign cos_o   = cos_q;

endmodule

`default_nettype wire

[rtl/gcrb_combine.sv]
`timescale 1ns / 1ps
`default_nettype none

// y = sd*c2, x = c1*s2 - (s1*c2)*cd, Q30 floor products
module gcrb_combine import gcrb_pkg::*; (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  input  logic [NUM_LANES-1:0][SC_W-1:0] sin_i,
  input  logic [NUM_LANES-1:0][SC_W-1:0] cos_i,
  output logic                           valid_o,
  output logic [SC_W-1:0]                yv_o,
  output logic [XV_W-1:0]                xv_o
);

  logic [2:0] vld_q;
  logic signed [SC_W-1:0] y1_q, a1_q, b1_q, cd1_q;
  logic signed [SC_W-1:0] y2_q, a2_q, c2_q;
  logic signed [SC_W-1:0] y3_q;
  logic signed [XV_W-1:0] x3_q;

  logic signed [SC_W-1:0]   s1, c1, s2, c2, sd, cd;
  logic signed [2*SC_W-1:0] py, pa, pb, pc;

  assign s1 = $signed(sin_i[LN_OWN]);
  assign c1 = $signed(cos_i[LN_OWN]);
  assign s2 = $signed(sin_i[LN_GOAL]);
  assign c2 = $signed(cos_i[LN_GOAL]);
  assign sd = $signed(sin_i[LN_DLON]);
  assign cd = $signed(cos_i[LN_DLON]);

  always_comb begin
    py = sd * c2;
    pa = c1 * s2;
    pb = s1 * c2;
    pc = b1_q * cd1_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    y1_q  <= SC_W'(py >>> 30);
    a1_q  <= SC_W'(pa >>> 30);
    b1_q  <= SC_W'(pb >>> 30);
    cd1_q <= cd;
    y2_q  <= y1_q;
    a2_q  <= a1_q;
    c2_q  <= SC_W'(pc >>> 30);
    y3_q  <= y2_q;
    x3_q  <= XV_W'(a2_q) - XV_W'(c2_q);
  end

  assign valid_o = vld_q[2];
  assign yv_o    = y3_q;
  assign xv_o    = x3_q;

endmodule

`default_nettype wire

[rtl/gcrb_atan.sv]
`timescale 1ns / 1ps
`default_nettype none

// vectoring-mode CORDIC, one register per iteration
module gcrb_atan import gcrb_pkg::*; #(
  parameter int unsigned STAGES = CORDIC_STAGES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  logic [SC_W-1:0]   yv_i,
  input  logic [XV_W-1:0]   xv_i,
  output logic              valid_o,
  output logic              zero_o,
  output logic [TURN_W-1:0] turn_o
);

  localparam int unsigned CV_W = 36;

  logic                   vld_q  [STAGES+1];
  logic                   zero_q [STAGES+1];
  logic signed [CV_W-1:0] x_q    [STAGES+1];
  logic signed [CV_W-1:0] y_q    [STAGES+1];
  logic [TURN_W-1:0]      z_q    [STAGES+1];

  logic signed [CV_W-1:0] xe, ye;
  assign xe = CV_W'($signed(xv_i));
  assign ye = CV_W'($signed(yv_i));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < STAGES + 1; s++) vld_q[s] <= 1'b0;
    end else begin
      vld_q[0] <= valid_i;
      for (int s = 1; s < STAGES + 1; s++) vld_q[s] <= vld_q[s-1];
    end
  end

  // left half plane: mirror and start at half a turn
  always_ff @(posedge clk_i) begin
    zero_q[0] <= (xv_i == '0) && (yv_i == '0);
    if (xe[CV_W-1]) begin
      x_q[0] <= -xe;
      y_q[0] <= -ye;
      z_q[0] <= TURN_HALF;
    end else begin
      x_q[0] <= xe;
      y_q[0] <= ye;
      z_q[0] <= '0;
    end
  end

  for (genvar gs = 0; gs < STAGES; gs++) begin : g_iter
    localparam logic [4:0] K = 5'(gs);
    always_ff @(posedge clk_i) begin
      zero_q[gs+1] <= zero_q[gs];
      if (y_q[gs] > 0) begin
        x_q[gs+1] <= x_q[gs] + (y_q[gs] >>> gs);
        y_q[gs+1] <= y_q[gs] - (x_q[gs] >>> gs);
        z_q[gs+1] <= z_q[gs] + atan_turn(K);
      end else begin
        x_q[gs+1] <= x_q[gs] - (y_q[gs] >>> gs);
        y_q[gs+1] <= y_q[gs] + (x_q[gs] >>> gs);
        z_q[gs+1] <= z_q[gs] - atan_turn(K);
      end
    end
  end

  assign valid_o = vld_q[STAGES];
  assign zero_o  = zero_q[STAGES];
  assign turn_o  = z_q[STAGES];

endmodule

`default_nettype wire

[rtl/great_circle_relative_bearing.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel  Handshake          Fields
// input    start_i / busy_o   own_lat_i, own_lon_i, goal_lat_i, goal_lon_i, compass_azimuth_i
// result   done_o             relative_bearing_o, degrees * 65536 in [0,360)
//
// One word per clock. Each CORDIC iteration is one register; around them sit 3
// stages of degree-to-turn, 2 of fold and sign fix, 3 of Q30 products, 1 of the
// arctangent half-plane mirror and 2 of turn-to-degree and heading wrap.
// Reset clears only the valid bits. The receiver cannot stall and busy_o
// stays low, so the pipe advances every cycle.
module great_circle_relative_bearing import gcrb_pkg::*; #(
  parameter int unsigned CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  output logic             busy_o,
  input  logic [LAT_W-1:0] own_lat_i,
  input  logic [LON_W-1:0] own_lon_i,
  input  logic [LAT_W-1:0] goal_lat_i,
  input  logic [LON_W-1:0] goal_lon_i,
  input  logic [ANG_W-1:0] compass_azimuth_i,
  output logic             done_o,
  output logic [ANG_W-1:0] relative_bearing_o
);

  // heading rides alongside until the bearing register
  localparam int unsigned AZ_DLY = pipe_latency(CORDIC_STAGES) - 1;

  logic                             fr_vld;
  logic [NUM_LANES-1:0][TURN_W-1:0] fr_turn;
  logic                             sc_vld;
  logic [NUM_LANES-1:0][SC_W-1:0]   sc_sin, sc_cos;
  logic                             cb_vld;
  logic [SC_W-1:0]                  cb_yv;
  logic [XV_W-1:0]                  cb_xv;
  logic                             at_vld, at_zero;
  logic [TURN_W-1:0]                at_turn;

  logic [ANG_W-1:0] az_line_q [AZ_DLY];
  logic [ANG_W-1:0] az_wrap;
  logic             t1_vld_q, t2_vld_q;
  logic [ANG_W-1:0] bearing_q, rel_q;

  logic [40:0]      deg_prod;
  logic [ANG_W-1:0] deg_r;
  logic [ANG_W-1:0] bearing_d;
  logic [ANG_W:0]   rel_d;

  logic accept;
  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  gcrb_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (accept),
    .own_lat_i  (own_lat_i),
    .own_lon_i  (own_lon_i),
    .goal_lat_i (goal_lat_i),
    .goal_lon_i (goal_lon_i),
    .valid_o    (fr_vld),
    .turn_o     (fr_turn)
  );

  gcrb_sincos #(.STAGES(CORDIC_STAGES)) u_sincos (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (fr_vld),
    .turn_i  (fr_turn),
    .valid_o (sc_vld),
    .sin_o   (sc_sin),
    .cos_o   (sc_cos)
  );

  gcrb_combine u_combine (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sc_vld),
    .sin_i   (sc_sin),
    .cos_i   (sc_cos),
    .valid_o (cb_vld),
    .yv_o    (cb_yv),
    .xv_o    (cb_xv)
  );

  gcrb_atan #(.STAGES(CORDIC_STAGES)) u_atan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (cb_vld),
    .yv_i    (cb_yv),
    .xv_i    (cb_xv),
    .valid_o (at_vld),
    .zero_o  (at_zero),
    .turn_o  (at_turn)
  );

  // heading reduced once on entry
  assign az_wrap = (compass_azimuth_i >= FULL_CIRCLE) ?
                   (compass_azimuth_i - FULL_CIRCLE) : compass_azimuth_i;

  always_ff @(posedge clk_i) begin
    az_line_q[0] <= az_wrap;
    for (int i = 1; i < AZ_DLY; i++) az_line_q[i] <= az_line_q[i-1];
  end

  // turn -> degrees, round half up; a full circle folds to zero, as does a zero vector
  always_comb begin
    deg_prod  = 41'(at_turn) * 41'd360 + 41'(1 << (31 - ANGLE_FRAC_BITS));
    deg_r     = deg_prod[40:32-ANGLE_FRAC_BITS];
    bearing_d = (at_zero || (deg_r >= FULL_CIRCLE)) ? '0 : deg_r;
  end

  // subtract heading, wrap into [0,360)
  always_comb begin
    rel_d = {1'b0, bearing_q} - {1'b0, az_line_q[AZ_DLY-1]};
    if (bearing_q < az_line_q[AZ_DLY-1]) begin
      rel_d = rel_d + {1'b0, FULL_CIRCLE};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t1_vld_q <= 1'b0;
      t2_vld_q <= 1'b0;
    end else begin
      t1_vld_q <= at_vld;
      t2_vld_q <= t1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    bearing_q <= bearing_d;
    rel_q     <= rel_d[ANG_W-1:0];
  end

  assign done_o             = t2_vld_q;
  assign relative_bearing_o = rel_q;

endmodule

`default_nettype wire

[rtl/gcrb_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module gcrb_checker import gcrb_pkg::*; #(
  parameter int unsigned CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             start_i,
  input logic             busy_o,
  input logic             done_o,
  input logic [ANG_W-1:0] relative_bearing_o
);

  localparam int unsigned LAT = pipe_latency(CORDIC_STAGES);

  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy_o)
    else $error("busy raised");

  a_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (relative_bearing_o < FULL_CIRCLE))
    else $error("bearing out of range");

  a_has_source: assert property (@(posedge clk_i)
    done_o |-> $past(start_i && !busy_o, LAT))
    else $error("result without a word taken");

  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |=> !done_o)
    else $error("result right after reset");

endmodule

bind great_circle_relative_bearing gcrb_checker #(
  .CORDIC_STAGES(CORDIC_STAGES)
) u_gcrb_checker (.*);

`default_nettype wire
